// File: sv/pdrd_pkg.sv
// Shared types, constants and helpers of the per-device release debouncer.
`timescale 1ns / 1ps

package pdrd_pkg;

    // Table size and payload width kept per entry.
    localparam int DEVICES      = 16;
    localparam int PAYLOAD_BITS = 32;

    // Fixed field widths of the item and result beats.
    localparam int DEV_W  = 4;
    localparam int DATA_W = 32;
    localparam int HOLD_W = 16;
    localparam int CMD_W  = 2;

    localparam int IDX_BITS   = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int STORE_BITS = (PAYLOAD_BITS < DATA_W) ? PAYLOAD_BITS : DATA_W;

    // Queue depths, powers of two so the pointers wrap on their own.
    localparam int OPQ_DEPTH  = 2;
    localparam int OPQ_AW     = $clog2(OPQ_DEPTH);
    localparam int RESQ_DEPTH = 4;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);

    // Configuration port.
    localparam int ADDR_W     = 3;
    localparam int REG_IDX_W  = ADDR_W - 2;
    localparam int APB_DATA_W = 32;
    localparam logic [REG_IDX_W-1:0] REG_HOLDOFF = REG_IDX_W'(0);
    localparam logic [HOLD_W-1:0]    HOLD_RESET  = HOLD_W'(50);

    // Result kinds.
    localparam logic KIND_HIT     = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_HIT     = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        OP_HIT_CHK = 3'd0,
        OP_HIT_FWD = 3'd1,
        OP_RELEASE = 3'd2,
        OP_TICK    = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op_kind;

    typedef struct packed {
        t_op_kind               kind;
        logic [DEV_W-1:0]       dev;
        logic [STORE_BITS-1:0]  data;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_op_bus;

    typedef struct packed {
        logic               kind;
        logic [DEV_W-1:0]   dev;
        logic [DATA_W-1:0]  data;
        logic               last;
    } t_res;

    // True when the device index has an entry in the table.
    function automatic logic in_table(input logic [DEV_W-1:0] dev);
        return (int'(dev) < DEVICES);
    endfunction

endpackage

// File: sv/pdrd_front.sv
// Front end: takes item beats, classifies them and queues the resulting operations.
`timescale 1ns / 1ps

module pdrd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [pdrd_pkg::CMD_W-1:0]    i_cmd,
    input  logic [pdrd_pkg::DEV_W-1:0]    i_device,
    input  logic [pdrd_pkg::DATA_W-1:0]   i_event_data,
    input  logic                          i_op_pop,
    output pdrd_pkg::t_op_bus             o_op
);
    import pdrd_pkg::*;

    t_op                r_q [OPQ_DEPTH];
    logic [OPQ_AW-1:0]  r_wp;
    logic [OPQ_AW-1:0]  r_rp;
    logic [OPQ_AW:0]    r_cnt;
    t_op                w_op;
    logic               w_keep;
    logic               w_wr;
    logic               w_rd;

    // A release for a device outside the table has no effect and is dropped here.
    always_comb begin
        w_op.dev  = i_device;
        w_op.data = STORE_BITS'(i_event_data);
        w_op.kind = OP_TICK;
        w_keep    = 1'b1;
        unique case (t_cmd'(i_cmd))
            CMD_HIT: begin
                w_op.kind = in_table(i_device) ? OP_HIT_CHK : OP_HIT_FWD;
            end
            CMD_RELEASE: begin
                w_op.kind = OP_RELEASE;
                w_keep    = in_table(i_device);
            end
            CMD_TICK: begin
                w_op.kind = OP_TICK;
            end
            CMD_CLEAR: begin
                w_op.kind = OP_CLEAR;
            end
        endcase
    end

    assign o_full   = (r_cnt == (OPQ_AW+1)'(OPQ_DEPTH));
    assign w_wr     = i_push && !o_full && w_keep;
    assign w_rd     = i_op_pop && (r_cnt != '0);
    assign o_op.valid = (r_cnt != '0);
    assign o_op.op    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= OPQ_AW'(r_wp + 1'b1);
            end
            if (w_rd) begin
                r_rp <= OPQ_AW'(r_rp + 1'b1);
            end
            r_cnt <= r_cnt + (OPQ_AW+1)'(w_wr) - (OPQ_AW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_op;
        end
    end

endmodule

// File: sv/pdrd_back.sv
// Back end: device table, holdoff countdowns and the tick scan over all entries.
`timescale 1ns / 1ps

module pdrd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pdrd_pkg::HOLD_W-1:0]   i_hold,
    input  pdrd_pkg::t_op_bus             i_op,
    output logic                          o_op_pop,
    input  logic                          i_res_full,
    output logic                          o_res_push,
    output pdrd_pkg::t_res                o_res
);
    import pdrd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    t_state                 r_state, n_state;
    logic [DEVICES-1:0]     r_pend, n_pend;
    logic [IDX_BITS-1:0]    r_idx, n_idx;
    logic                   r_hv, n_hv;
    logic [DEV_W-1:0]       r_hdev, n_hdev;
    logic [STORE_BITS-1:0]  r_hdata, n_hdata;

    logic [HOLD_W-1:0]      r_cnt_mem [DEVICES];
    logic [STORE_BITS-1:0]  r_pay_mem [DEVICES];
    logic [HOLD_W-1:0]      r_rd_cnt;
    logic [STORE_BITS-1:0]  r_rd_pay;

    logic [IDX_BITS-1:0]    w_ra;
    logic [IDX_BITS-1:0]    w_wa;
    logic                   w_cnt_we;
    logic [HOLD_W-1:0]      w_cnt_wd;
    logic                   w_pay_we;
    logic [IDX_BITS-1:0]    w_op_idx;
    logic                   w_expire;
    logic                   w_decr;
    logic                   w_stall;
    logic                   w_last_idx;

    assign w_op_idx   = IDX_BITS'(i_op.op.dev);
    assign w_expire   = r_pend[r_idx] && (r_rd_cnt <= HOLD_W'(1));
    assign w_decr     = r_pend[r_idx] && !w_expire;
    assign w_stall    = w_expire && r_hv && i_res_full;
    assign w_last_idx = (r_idx == IDX_BITS'(DEVICES - 1));

    always_comb begin
        n_state    = r_state;
        n_pend     = r_pend;
        n_idx      = r_idx;
        n_hv       = r_hv;
        n_hdev     = r_hdev;
        n_hdata    = r_hdata;
        o_op_pop   = 1'b0;
        o_res_push = 1'b0;
        o_res.kind = KIND_HIT;
        o_res.dev  = i_op.op.dev;
        o_res.data = DATA_W'(i_op.op.data);
        o_res.last = 1'b1;
        w_ra       = '0;
        w_wa       = w_op_idx;
        w_cnt_we   = 1'b0;
        w_cnt_wd   = i_hold;
        w_pay_we   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_op.valid) begin
                    unique case (i_op.op.kind)
                        OP_HIT_CHK: begin
                            if (r_pend[w_op_idx]) begin
                                // The hit cancels the pending release and is absorbed.
                                n_pend[w_op_idx] = 1'b0;
                                o_op_pop         = 1'b1;
                            end else if (!i_res_full) begin
                                o_res_push = 1'b1;
                                o_op_pop   = 1'b1;
                            end
                        end
                        OP_HIT_FWD: begin
                            if (!i_res_full) begin
                                o_res_push = 1'b1;
                                o_op_pop   = 1'b1;
                            end
                        end
                        OP_RELEASE: begin
                            n_pend[w_op_idx] = 1'b1;
                            w_cnt_we         = 1'b1;
                            w_pay_we         = 1'b1;
                            o_op_pop         = 1'b1;
                        end
                        OP_TICK: begin
                            o_op_pop = 1'b1;
                            n_idx    = '0;
                            n_state  = ST_SCAN;
                        end
                        OP_CLEAR: begin
                            n_pend   = '0;
                            o_op_pop = 1'b1;
                        end
                        default: begin
                            o_op_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Entry r_idx was read last cycle; the next is read now unless stalled.
                w_wa     = r_idx;
                w_cnt_wd = r_rd_cnt - HOLD_W'(1);
                o_res.kind = KIND_RELEASE;
                o_res.dev  = r_hdev;
                o_res.data = DATA_W'(r_hdata);
                o_res.last = 1'b0;
                if (w_stall) begin
                    w_ra = r_idx;
                end else begin
                    w_ra = IDX_BITS'(r_idx + 1'b1);
                    if (w_expire) begin
                        n_pend[r_idx] = 1'b0;
                        o_res_push    = r_hv;
                        n_hv          = 1'b1;
                        n_hdev        = DEV_W'(r_idx);
                        n_hdata       = r_rd_pay;
                    end
                    w_cnt_we = w_decr;
                    if (w_last_idx) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx = IDX_BITS'(r_idx + 1'b1);
                    end
                end
            end
            ST_FLUSH: begin
                o_res.kind = KIND_RELEASE;
                o_res.dev  = r_hdev;
                o_res.data = DATA_W'(r_hdata);
                o_res.last = 1'b1;
                if (!r_hv) begin
                    n_state = ST_IDLE;
                end else if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_hv       = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= '0;
            r_idx   <= '0;
            r_hv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_idx   <= n_idx;
            r_hv    <= n_hv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdev  <= n_hdev;
        r_hdata <= n_hdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_cnt_mem[w_wa] <= w_cnt_wd;
        end
        if (w_pay_we) begin
            r_pay_mem[w_wa] <= i_op.op.data;
        end
        r_rd_cnt <= r_cnt_mem[w_ra];
        r_rd_pay <= r_pay_mem[w_ra];
    end

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_op.valid && i_op.op.kind == OP_CLEAR) |=> (r_pend == '0))
        else $error("pending flags survive a clear");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result pushed into a full queue");

    a_mid_only_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && !o_res.last) |-> (r_state == ST_SCAN && r_hv))
        else $error("non-final result outside the scan");

    a_flush_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && !r_hv) |=> (r_state == ST_IDLE))
        else $error("flush did not return to idle");

endmodule

// File: sv/pdrd_resq.sv
// Result queue between the back end and the result port.
`timescale 1ns / 1ps

module pdrd_resq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pdrd_pkg::t_res  i_res,
    input  logic            i_pop,
    output logic            o_empty,
    output logic            o_full,
    output pdrd_pkg::t_res  o_res
);
    import pdrd_pkg::*;

    t_res               r_q [RESQ_DEPTH];
    logic [RESQ_AW-1:0] r_wp;
    logic [RESQ_AW-1:0] r_rp;
    logic [RESQ_AW:0]   r_cnt;
    logic               w_wr;
    logic               w_rd;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (RESQ_AW+1)'(RESQ_DEPTH));
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_res   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= RESQ_AW'(r_wp + 1'b1);
            end
            if (w_rd) begin
                r_rp <= RESQ_AW'(r_rp + 1'b1);
            end
            r_cnt <= r_cnt + (RESQ_AW+1)'(w_wr) - (RESQ_AW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

// File: sv/per_device_release_debouncer_core.sv
// Top level of the per-device release debouncer: register port and the three stages.
`timescale 1ns / 1ps

// Channel   Handshake                    Beat contents
// config    psel/penable/pwrite, pready  paddr, pwdata -> holdoff_ticks (reg 0, bits 15:0)
// item      push / full                  i_cmd, i_device, i_event_data
// result    pop / empty                  o_kind, o_out_device, o_out_data, o_last
//
// The front end takes one item beat per cycle, while not full, into a two-entry operation queue.
// In the back end a hit, release or clear is handled from the idle state; a
// tick scans the table one entry per cycle through the countdown memory, except
// while a full result queue stalls the scan, and then flushes the held release.
// Reset is synchronous and active low: nothing is pending and holdoff is 50.
// Either side can stall the other only through the queues in between.

module per_device_release_debouncer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pdrd_pkg::ADDR_W-1:0]       paddr,
    input  logic [pdrd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [pdrd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // Item channel
    input  logic                              push,
    output logic                              full,
    input  logic [pdrd_pkg::CMD_W-1:0]        i_cmd,
    input  logic [pdrd_pkg::DEV_W-1:0]        i_device,
    input  logic [pdrd_pkg::DATA_W-1:0]       i_event_data,
    // Result channel
    output logic                              empty,
    input  logic                              pop,
    output logic                              o_kind,
    output logic [pdrd_pkg::DEV_W-1:0]        o_out_device,
    output logic [pdrd_pkg::DATA_W-1:0]       o_out_data,
    output logic                              o_last
);
    import pdrd_pkg::*;

    logic [HOLD_W-1:0]    r_holdoff;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_cfg_wr;
    t_op_bus              w_op;
    logic                 w_op_pop;
    logic                 w_res_push;
    logic                 w_res_full;
    t_res                 w_res_in;
    t_res                 w_res_out;

    // The register port never waits; the register index is the address over 4.
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    // Reads of an address with no register return zero.
    assign prdata = (w_reg_idx == REG_HOLDOFF) ? APB_DATA_W'(r_holdoff) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holdoff <= HOLD_RESET;
        end else if (w_cfg_wr && (w_reg_idx == REG_HOLDOFF)) begin
            r_holdoff <= pwdata[HOLD_W-1:0];
        end
    end

    // The front end classifies each item beat so the back end only has to
    // look up the table; releases for devices beyond the table die here.
    pdrd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd        (i_cmd),
        .i_device     (i_device),
        .i_event_data (i_event_data),
        .i_op_pop     (w_op_pop),
        .o_op         (w_op)
    );

    // The back end owns the pending flags, countdowns and held payloads. A tick
    // holds back the most recent expired release so it can mark the final one.
    pdrd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_hold     (r_holdoff),
        .i_op       (w_op),
        .o_op_pop   (w_op_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_res_in)
    );

    // Finished result beats wait here, so the back end keeps working while the
    // consumer is slow.
    pdrd_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res_in),
        .i_pop   (pop),
        .o_empty (empty),
        .o_full  (w_res_full),
        .o_res   (w_res_out)
    );

    assign o_kind       = w_res_out.kind;
    assign o_out_device = w_res_out.dev;
    assign o_out_data   = w_res_out.data;
    assign o_last       = w_res_out.last;

endmodule

// File: sim/pdrd_forward_checker.sv
// Checker for the debouncer: predicts the forwarded beats of each item beat and compares them.
`timescale 1ns / 1ps

module pdrd_forward_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [pdrd_pkg::ADDR_W-1:0]       i_paddr,
    input  logic [pdrd_pkg::APB_DATA_W-1:0]   i_pwdata,
    input  logic [pdrd_pkg::APB_DATA_W-1:0]   i_prdata,
    input  logic                              i_pready,
    input  logic                              i_push,
    input  logic                              i_full,
    input  logic [pdrd_pkg::CMD_W-1:0]        i_cmd,
    input  logic [pdrd_pkg::DEV_W-1:0]        i_device,
    input  logic [pdrd_pkg::DATA_W-1:0]       i_event_data,
    input  logic                              i_empty,
    input  logic                              i_pop,
    input  logic                              i_kind,
    input  logic [pdrd_pkg::DEV_W-1:0]        i_out_device,
    input  logic [pdrd_pkg::DATA_W-1:0]       i_out_data,
    input  logic                              i_last,
    output int                                o_fail_count,
    output int                                o_outstanding
);

    import pdrd_pkg::*;

    localparam int MAX_REPORTS = 40;
    localparam logic [DATA_W-1:0] KEEP_MASK = (PAYLOAD_BITS >= DATA_W) ? {DATA_W{1'b1}} :
                                              DATA_W'((64'd1 << PAYLOAD_BITS) - 64'd1);

    logic [HOLD_W-1:0] holdoff;
    logic              armed      [DEVICES];
    logic [HOLD_W-1:0] ticks_left [DEVICES];
    logic [DATA_W-1:0] held_data  [DEVICES];
    t_res              forwards_due [$];
    int                fails = 0;

    function automatic void report(input string msg);
        fails++;
        if (fails <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            report($sformatf("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got));
        end
    endfunction

    // Applies one accepted item beat to the table and queues the beats it forwards.
    function automatic void debounce_item(input t_cmd cmd, input logic [DEV_W-1:0] dev,
                                          input logic [DATA_W-1:0] data);
        t_res burst [$];
        t_res beat;
        logic [DATA_W-1:0] kept;
        kept = data & KEEP_MASK;
        beat.last = 1'b0;
        case (cmd)
            CMD_HIT: begin
                if (int'(dev) < DEVICES && armed[dev]) begin
                    // The hit cancels the pending release and is swallowed.
                    armed[dev] = 1'b0;
                end else begin
                    beat.kind = KIND_HIT;
                    beat.dev  = dev;
                    beat.data = kept;
                    burst = {burst, beat};
                end
            end
            CMD_RELEASE: begin
                if (int'(dev) < DEVICES) begin
                    armed[dev]      = 1'b1;
                    ticks_left[dev] = holdoff;
                    held_data[dev]  = kept;
                end
            end
            CMD_TICK: begin
                for (int i = 0; i < DEVICES; i++) begin
                    if (armed[i]) begin
                        if (ticks_left[i] <= 1) begin
                            armed[i]  = 1'b0;
                            beat.kind = KIND_RELEASE;
                            beat.dev  = DEV_W'(i);
                            beat.data = held_data[i];
                            burst = {burst, beat};
                        end else begin
                            ticks_left[i] = ticks_left[i] - 1'b1;
                        end
                    end
                end
            end
            default: begin
                foreach (armed[i]) armed[i] = 1'b0;
            end
        endcase
        foreach (burst[k]) begin
            beat      = burst[k];
            beat.last = (k == burst.size() - 1);
            forwards_due = {forwards_due, beat};
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            holdoff = HOLD_RESET;
            foreach (armed[i]) armed[i] = 1'b0;
            forwards_due.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr[ADDR_W-1:2] == REG_HOLDOFF) begin
                if (i_pwrite) begin
                    holdoff = i_pwdata[HOLD_W-1:0];
                end else begin
                    check_field("prdata", 64'(holdoff), 64'(i_prdata));
                end
            end
            // A result beat seen at this edge always belongs to an earlier item beat.
            if (i_pop && !i_empty) begin
                if (forwards_due.size() == 0) begin
                    report($sformatf({"result beat with nothing expected: kind %0d device %0d",
                                      " data 0x%h last %0d"},
                                     i_kind, i_out_device, i_out_data, i_last));
                end else begin
                    want = forwards_due.pop_front();
                    check_field("kind", 64'(want.kind), 64'(i_kind));
                    check_field("out_device", 64'(want.dev), 64'(i_out_device));
                    check_field("out_data", 64'(want.data), 64'(i_out_data));
                    check_field("last", 64'(want.last), 64'(i_last));
                end
            end
            if (i_push && !i_full) begin
                debounce_item(t_cmd'(i_cmd), i_device, i_event_data);
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= forwards_due.size();
    end

endmodule

// File: sim/per_device_release_debouncer_core_test.sv
// Testbench top for the per-device release debouncer: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

// The block is driven through its item queue and drained through its result
// queue, both with random per-beat idling. A separate checker module watches
// all three channels, predicts every forwarded beat and counts failures; this
// module only produces stimulus and decides the outcome.
//
// Order of the run:
//   - a short directed sequence at the reset holdoff of 50 ticks (forwarded
//     hits, a hit that cancels a release, a release that replaces another,
//     clear, ticks with nothing to expire),
//   - a tick-heavy random phase so the directed releases can expire at holdoff 50,
//   - random phases at holdoff 0, 1, 3, 65535 and 2, with full-table bursts,
//     a long stall of the result side and a write to an unused register slot.

module per_device_release_debouncer_core_test;

    import pdrd_pkg::*;

    localparam int DRAIN_CYCLES   = 64;    // covers three ticks in flight, two queued and one scanning
    localparam int RX_HOLD_CYCLES = 150;   // long enough to fill both internal queues
    localparam int STALL_LIMIT    = 4000;  // cycles with no beat moving before giving up
    localparam logic [ADDR_W-1:0] HOLDOFF_ADDR = ADDR_W'(4 * int'(REG_HOLDOFF));
    localparam logic [ADDR_W-1:0] NO_REG_ADDR  = ADDR_W'(4 * (int'(REG_HOLDOFF) + 1));

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push;
    logic                  full;
    logic [CMD_W-1:0]      i_cmd;
    logic [DEV_W-1:0]      i_device;
    logic [DATA_W-1:0]     i_event_data;
    logic                  empty;
    logic                  pop;
    logic                  o_kind;
    logic [DEV_W-1:0]      o_out_device;
    logic [DATA_W-1:0]     o_out_data;
    logic                  o_last;

    int fail_count;
    int outstanding;
    int items_sent    = 0;
    int results_taken = 0;
    int tx_calm       = 0;
    int rx_calm       = 0;
    bit hold_results  = 1'b0;

    per_device_release_debouncer_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_device     (i_device),
        .i_event_data (i_event_data),
        .empty        (empty),
        .pop          (pop),
        .o_kind       (o_kind),
        .o_out_device (o_out_device),
        .o_out_data   (o_out_data),
        .o_last       (o_last)
    );

    pdrd_forward_checker forward_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .i_push        (push),
        .i_full        (full),
        .i_cmd         (i_cmd),
        .i_device      (i_device),
        .i_event_data  (i_event_data),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_kind        (o_kind),
        .i_out_device  (o_out_device),
        .i_out_data    (o_out_data),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Idle cycles before a beat: usually drawn at random, but now and then a run of
    // back-to-back beats so the block also sees full-rate traffic.
    function automatic int pick_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    // Offers one item beat and returns at the falling edge after it is taken.
    task automatic send_item(input t_cmd cmd, input logic [DEV_W-1:0] dev,
                             input logic [DATA_W-1:0] data);
        int gap;
        gap = pick_wait(tx_calm);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd        <= cmd;
        i_device     <= dev;
        i_event_data <= data;
        push         <= 1'b1;
        do @(posedge i_clk); while (full);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Random commands by percentage; the rest of 100 goes to clear. Half of
    // the devices are drawn from a small hot set so that hits often land on
    // a pending release and releases often replace one.
    task automatic send_random(input int count, input int hit_pct, input int rel_pct,
                               input int tick_pct);
        int               roll;
        t_cmd             cmd;
        logic [DEV_W-1:0] dev;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < hit_pct) begin
                cmd = CMD_HIT;
            end else if (roll < hit_pct + rel_pct) begin
                cmd = CMD_RELEASE;
            end else if (roll < hit_pct + rel_pct + tick_pct) begin
                cmd = CMD_TICK;
            end else begin
                cmd = CMD_CLEAR;
            end
            if ($urandom_range(0, 1) == 0) begin
                dev = DEV_W'($urandom_range(0, 3));
            end else begin
                dev = DEV_W'($urandom_range(0, DEVICES - 1));
            end
            send_item(cmd, dev, $urandom);
        end
    endtask

    // Arms every device, in descending order, then ticks: the last tick
    // forwards a whole table's worth of releases in one burst.
    task automatic release_all_then_tick(input int ticks);
        for (int d = DEVICES - 1; d >= 0; d--) begin
            send_item(CMD_RELEASE, DEV_W'(d), $urandom);
        end
        repeat (ticks) send_item(CMD_TICK, DEV_W'($urandom_range(0, DEVICES - 1)), $urandom);
    endtask

    // Stops offering items, waits for every predicted beat, then lets any
    // silent work (releases, clears, empty ticks) finish inside the block.
    task automatic settle();
        push <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // One register transfer: setup cycle, access cycle, then a bus idle cycle.
    task automatic reg_access(input logic write, input logic [ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    // The checker compares the read-back value with the holdoff it tracks.
    task automatic set_holdoff(input logic [APB_DATA_W-1:0] value);
        settle();
        reg_access(1'b1, HOLDOFF_ADDR, value);
        reg_access(1'b0, HOLDOFF_ADDR, '0);
    endtask

    // Result side: random idling, plus one long hold when the sender asks.
    initial begin
        int gap;
        pop = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = pick_wait(rx_calm);
            if (hold_results) begin
                hold_results = 1'b0;
                gap = RX_HOLD_CYCLES;
            end
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            results_taken++;
            @(negedge i_clk);
        end
    end

    // Watchdog: a run where no beat moves for too long has hung.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        push         = 1'b0;
        i_cmd        = CMD_HIT;
        i_device     = '0;
        i_event_data = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The read-back must show the reset holdoff.
        reg_access(1'b0, HOLDOFF_ADDR, '0);

        // Directed sequence at the reset holdoff.
        send_item(CMD_TICK,    4'd0,  32'h0000_0000);  // nothing pending, no beat
        send_item(CMD_HIT,     4'd0,  32'h0000_0000);  // forwarded at once
        send_item(CMD_HIT,     4'd15, 32'hFFFF_FFFF);  // forwarded at once
        send_item(CMD_RELEASE, 4'd15, 32'hFFFF_FFFF);
        send_item(CMD_HIT,     4'd15, 32'h1234_5678);  // cancels the release, dropped
        send_item(CMD_HIT,     4'd15, 32'h8765_4321);  // nothing pending now: forwarded
        send_item(CMD_RELEASE, 4'd3,  32'hAAAA_AAAA);
        send_item(CMD_RELEASE, 4'd3,  32'h5555_5555);  // replaces the earlier release
        send_item(CMD_RELEASE, 4'd0,  32'h0000_0000);
        send_item(CMD_TICK,    4'd9,  32'hDEAD_BEEF);  // only counts down
        send_item(CMD_CLEAR,   4'd6,  32'h0000_0001);  // drops everything pending
        send_item(CMD_TICK,    4'd12, 32'h8000_0000);  // nothing left to expire
        send_item(CMD_HIT,     4'd3,  32'h0BAD_F00D);  // cleared release: forwarded
        send_item(CMD_RELEASE, 4'd1,  32'h0F0F_0F0F);
        send_item(CMD_RELEASE, 4'd14, 32'hF0F0_F0F0);
        send_item(CMD_TICK,    4'd5,  32'h7FFF_FFFF);

        // Mostly ticks, so releases armed at holdoff 50 can run out and expire.
        send_random(60, 8, 10, 80);

        // Holdoff 0 behaves as 1: every release goes out on the next tick.
        set_holdoff(32'd0);
        release_all_then_tick(1);
        send_random(40, 30, 35, 30);

        // Holdoff 1 with a long hold on the result side while items keep
        // coming, so both internal queues fill and the input backs up.
        set_holdoff(32'd1);
        hold_results = 1'b1;
        send_random(40, 45, 25, 27);

        // A write to the unused slot must leave the holdoff alone.
        settle();
        reg_access(1'b1, NO_REG_ADDR, $urandom);
        set_holdoff(32'd3);
        send_random(45, 25, 35, 35);

        // All ones on the bus: only the low half lands, the largest holdoff.
        // Releases armed in this phase never expire; only hits, clears and new releases
        // end them, while releases left over from the previous phase still run out.
        set_holdoff(32'hFFFF_FFFF);
        send_random(25, 35, 35, 25);

        set_holdoff(32'd2);
        release_all_then_tick(2);
        send_random(40, 25, 35, 35);

        settle();
        $display("Covered %0d item beats and %0d result beats at holdoff 50, 0, 1, 3, 65535, 2,",
                 items_sent, results_taken);
        $display("with full-table tick bursts, a long result stall and an unused register write.");
        if (fail_count == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/pdrd_pkg.sv
sv/pdrd_front.sv
sv/pdrd_back.sv
sv/pdrd_resq.sv
sv/per_device_release_debouncer_core.sv
sim/pdrd_forward_checker.sv
sim/per_device_release_debouncer_core_test.sv
